[rtl/lbp_pkg.sv]
// ----------------------------------------------------------------------------
// LBP texture histogram package
// Shared widths, limits and request codes of the texture histogram block.
// ----------------------------------------------------------------------------
package lbp_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int HEIGHT_MAX   = 1024;
	localparam int NUM_BINS     = 256;

	localparam int PIX_W        = 8;
	localparam int LINE_W       = 2 * PIX_W;
	localparam int BIN_W        = $clog2(NUM_BINS);
	localparam int COUNT_W      = 20;
	localparam int DIM_W        = 11;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int POS_W        = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
	localparam int DIM_MIN      = 3;

	localparam logic [COUNT_W-1:0] BIN_MAX = {COUNT_W{1'b1}};

	localparam int REQ_W        = 2;
	localparam int IN_DATA_W    = 2 * PIX_W;
	localparam int OUT_BITS     = COUNT_W + 1;
	localparam int OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

	localparam int CFG_IDX_W    = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	localparam int OFIFO_DEPTH  = 4;
	localparam int OPTR_W       = $clog2(OFIFO_DEPTH);
	localparam int OCNT_W       = $clog2(OFIFO_DEPTH + 1);

	typedef enum logic [REQ_W-1:0] {
		REQ_PIXEL = 2'd0,
		REQ_READ  = 2'd1,
		REQ_START = 2'd2
	} req_t;

	typedef struct packed {
		logic                 frame_complete;
		logic [COUNT_W-1:0]   bin_count;
	} result_t;

endpackage

[rtl/lbp_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/lbp_texture_histogram.sv]
// ----------------------------------------------------------------------------
// LBP texture histogram
// Local binary pattern codes of a raster pixel stream, collected in a
// 256-bin histogram that can be cleared and read back bin by bin.
// ----------------------------------------------------------------------------
// The block takes one request every clock cycle while tready is high: pixel,
// bin read or frame start. A pixel reads both line stores (one 1024 x 16
// RAM) in the cycle it is accepted, forms its code in the next cycle, and
// increments its bin in the cycle after that through a 256 x 20 RAM with a
// bypass for back-to-back hits on the same bin. A bin read goes via the s1
// and s2 registers to a four-word output queue; tready drops only when that
// queue and the reads in flight would overflow it. No clearing pass is
// needed after reset: a fill mark covers the line stores, valid bits the bins.
// ----------------------------------------------------------------------------
module lbp_texture_histogram
	import lbp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// pixel_value [7:0], bin_index [15:8]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// req_type [1:0]
	input  logic [REQ_W-1:0]      s_axis_tuser,

	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// bin_count [19:0], frame_complete [20], zero fill above
	output logic [OUT_DATA_W-1:0] m_axis_tdata,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DIM_W-1:0]      cfg_data
);

	logic [POS_W-1:0]   w_eff_q;
	logic [DIM_W-1:0]   h_eff_q;
	logic [COL_W-1:0]   col_q;
	logic [DIM_W-1:0]   row_q;
	logic [POS_W-1:0]   fill_q;

	logic [POS_W-1:0]   cfg_ext;
	logic [POS_W-1:0]   w_clamp;
	logic [DIM_W-1:0]   h_clamp;

	logic               acc;
	logic               is_pix;
	logic               is_rd;
	logic               is_start;
	logic               done;
	logic               live;
	logic               code_en;
	logic               wrap;
	logic [POS_W-1:0]   col_ext;
	logic [POS_W-1:0]   col_inc;

	logic               pix_s1;
	logic               code_en_s1;
	logic               rd_s1;
	logic               start_s1;
	logic [PIX_W-1:0]   p_s1;
	logic [COL_W-1:0]   idx_s1;
	logic [BIN_W-1:0]   bin_s1;
	logic               lvld_s1;
	logic               fc_s1;

	logic [LINE_W-1:0]  line_rdata;
	logic [PIX_W-1:0]   top;
	logic [PIX_W-1:0]   mid;
	logic [PIX_W-1:0]   ctr;
	logic [BIN_W-1:0]   code;
	logic [BIN_W-1:0]   haddr;
	logic [PIX_W-1:0]   win_q [6];

	logic               inc_s2;
	logic               rd_s2;
	logic [BIN_W-1:0]   addr_s2;
	logic               vld_s2;
	logic               fc_s2;
	logic [NUM_BINS-1:0] hvld_q;
	logic [COUNT_W-1:0] hist_rdata;
	logic [COUNT_W-1:0] old_cnt;
	logic [COUNT_W-1:0] new_cnt;
	logic               wrv_q;
	logic [BIN_W-1:0]   wra_q;
	logic [COUNT_W-1:0] wrd_q;

	result_t            ofifo_q [OFIFO_DEPTH];
	logic [OPTR_W-1:0]  wr_ptr_q;
	logic [OPTR_W-1:0]  rd_ptr_q;
	logic [OCNT_W-1:0]  cnt_q;
	logic [OCNT_W:0]    used;
	logic               push;
	logic               pop;
	result_t            push_word;

	assign cfg_ready = 1'b1;

	assign cfg_ext = POS_W'(cfg_data);
	assign w_clamp = (cfg_ext < POS_W'(DIM_MIN)) ? POS_W'(DIM_MIN) :
		(cfg_ext > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : cfg_ext;
	assign h_clamp = (cfg_data < DIM_W'(DIM_MIN)) ? DIM_W'(DIM_MIN) :
		(cfg_data > DIM_W'(HEIGHT_MAX)) ? DIM_W'(HEIGHT_MAX) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q <= POS_W'(WIDTH_RESET);
			h_eff_q <= DIM_W'(HEIGHT_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  w_eff_q <= w_clamp;
				REG_FRAME_HEIGHT: h_eff_q <= h_clamp;
				default: ;
			endcase
		end
	end

	assign acc = s_axis_tvalid && s_axis_tready;

	always_comb begin
		is_pix   = 1'b0;
		is_rd    = 1'b0;
		is_start = 1'b0;
		case (req_t'(s_axis_tuser))
			REQ_PIXEL: is_pix   = 1'b1;
			REQ_READ:  is_rd    = 1'b1;
			REQ_START: is_start = 1'b1;
			default: ;
		endcase
	end

	assign done    = row_q >= h_eff_q;
	assign live    = acc && is_pix && !done;
	assign col_ext = POS_W'(col_q);
	assign col_inc = col_ext + POS_W'(1);
	assign wrap    = col_inc >= w_eff_q;
	assign code_en = live && (row_q >= DIM_W'(2)) && (col_q >= COL_W'(2)) &&
		(col_ext <= w_eff_q - POS_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			fill_q <= '0;
		end else if (acc && is_start) begin
			col_q <= '0;
			row_q <= '0;
		end else if (live) begin
			if (wrap) begin
				col_q <= '0;
				row_q <= row_q + DIM_W'(1);
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
			if (col_ext >= fill_q) begin
				fill_q <= col_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1     <= 1'b0;
			code_en_s1 <= 1'b0;
			rd_s1      <= 1'b0;
			start_s1   <= 1'b0;
		end else begin
			pix_s1     <= live;
			code_en_s1 <= code_en;
			rd_s1      <= acc && is_rd;
			start_s1   <= acc && is_start;
		end
	end

	always_ff @(posedge clk) begin
		p_s1    <= s_axis_tdata[PIX_W-1:0];
		bin_s1  <= s_axis_tdata[PIX_W +: BIN_W];
		idx_s1  <= col_q;
		lvld_s1 <= col_ext < fill_q;
		fc_s1   <= done;
	end

	// Upper row in the high byte, middle row in the low byte.
	lbp_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (pix_s1),
		.waddr (idx_s1),
		.wdata ({mid, p_s1}),
		.raddr (col_q),
		.rdata (line_rdata)
	);

	assign top = lvld_s1 ? line_rdata[LINE_W-1:PIX_W] : '0;
	assign mid = lvld_s1 ? line_rdata[PIX_W-1:0] : '0;
	assign ctr = win_q[3];

	always_comb begin
		code    = '0;
		code[7] = win_q[0] > ctr;
		code[6] = win_q[1] > ctr;
		code[5] = top > ctr;
		code[4] = mid > ctr;
		code[3] = p_s1 > ctr;
		code[2] = win_q[5] > ctr;
		code[1] = win_q[4] > ctr;
		code[0] = win_q[2] > ctr;
	end

	always_ff @(posedge clk) begin
		if (pix_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= top;
			win_q[2] <= win_q[3];
			win_q[3] <= mid;
			win_q[4] <= win_q[5];
			win_q[5] <= p_s1;
		end
	end

	assign haddr = rd_s1 ? bin_s1 : code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_s2 <= 1'b0;
			rd_s2  <= 1'b0;
		end else begin
			inc_s2 <= code_en_s1;
			rd_s2  <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2 <= haddr;
		vld_s2  <= hvld_q[haddr];
		fc_s2   <= fc_s1;
	end

	lbp_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (NUM_BINS)
	) u_hist_ram (
		.clk   (clk),
		.we    (inc_s2),
		.waddr (addr_s2),
		.wdata (new_cnt),
		.raddr (haddr),
		.rdata (hist_rdata)
	);

	// The bin written in the previous cycle is not yet visible in the read data.
	assign old_cnt = (wrv_q && (wra_q == addr_s2)) ? wrd_q :
		(vld_s2 ? hist_rdata : '0);
	assign new_cnt = (old_cnt == BIN_MAX) ? old_cnt : old_cnt + COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvld_q <= '0;
			wrv_q  <= 1'b0;
		end else begin
			if (start_s1) begin
				hvld_q <= '0;
			end else if (inc_s2) begin
				hvld_q[addr_s2] <= 1'b1;
			end
			wrv_q <= inc_s2 && !start_s1;
		end
	end

	always_ff @(posedge clk) begin
		wra_q <= addr_s2;
		wrd_q <= new_cnt;
	end

	assign push                     = rd_s2;
	assign pop                      = m_axis_tvalid && m_axis_tready;
	assign push_word.frame_complete = fc_s2;
	assign push_word.bin_count      = old_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + OCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - OCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ofifo_q[wr_ptr_q] <= push_word;
		end
	end

	assign used = (OCNT_W + 1)'(cnt_q) + (OCNT_W + 1)'(rd_s1) + (OCNT_W + 1)'(rd_s2);
	assign s_axis_tready = used < (OCNT_W + 1)'(OFIFO_DEPTH);

	assign m_axis_tvalid = cnt_q != '0;
	assign m_axis_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, ofifo_q[rd_ptr_q]};

endmodule
